>>> sv/acl_pkg.sv
package acl_pkg;

    // Table sizes.
    localparam int MAX_ENTRIES = 16;
    localparam int MAX_GROUPS  = 16;

    // Entry address and count widths follow from the table sizes.
    localparam int ENT_AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int ENT_CW = $clog2(MAX_ENTRIES + 1);
    localparam int GRP_AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int GRP_CW = $clog2(MAX_GROUPS + 1);
    // Width used for index and pointer comparisons against the entry count.
    localparam int CMP_W  = ENT_CW + 5;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOAD   = 2'd2,
        CMD_CHECK  = 2'd3
    } t_acl_cmd;

    localparam logic [1:0] KIND_ALLOW = 2'd0;
    localparam logic [1:0] KIND_DENY  = 2'd1;

    typedef struct packed {
        t_acl_cmd    command;
        logic [1:0]  entry_type;
        logic [31:0] principal;
        logic        grp_flag;
        logic [15:0] perms;
        logic [3:0]  index;
    } t_acl_in;

    typedef struct packed {
        logic       status;
        logic       granted;
        logic [4:0] valid_entries;
    } t_acl_out;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] subject;
        logic        group;
        logic [15:0] mask;
    } t_acl_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_CHECK,
        S_RESP
    } t_acl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              capture;
        logic              rd_en;
        logic [ENT_AW-1:0] rd_addr;
        logic              wr_en;
        logic [ENT_AW-1:0] wr_addr;
        logic              wr_from_item;
        logic              ent_inc;
        logic              ent_dec;
        logic              grp_load;
        logic              grp_clr;
        logic              acc_clr;
        logic              acc_en;
        logic              resp;
        logic              resp_err;
        logic              resp_chk;
    } t_acl_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_acl_cmd          cmd;
        logic [3:0]        idx;
        logic [ENT_CW-1:0] ent_total;
        logic              ent_full;
        logic              grp_full;
        logic              idx_bad;
    } t_acl_stat;

endpackage

>>> sv/acl_ctrl.sv
module acl_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  acl_pkg::t_acl_stat  i_stat,
    output acl_pkg::t_acl_ctl   o_ctl
);

    acl_pkg::t_acl_state          r_state, n_state;
    logic [acl_pkg::ENT_AW-1:0]   r_ptr, n_ptr;
    logic                         r_err, n_err;
    logic [acl_pkg::CMP_W-1:0]    ptr_p1, ptr_p2, idx_p1, total_x;

    assign ptr_p1  = acl_pkg::CMP_W'(r_ptr) + acl_pkg::CMP_W'(1);
    assign ptr_p2  = acl_pkg::CMP_W'(r_ptr) + acl_pkg::CMP_W'(2);
    assign idx_p1  = acl_pkg::CMP_W'(i_stat.idx) + acl_pkg::CMP_W'(1);
    assign total_x = acl_pkg::CMP_W'(i_stat.ent_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= acl_pkg::S_IDLE;
            r_ptr   <= '0;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_err   <= n_err;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_err   = r_err;
        o_ctl   = '0;
        busy    = (r_state != acl_pkg::S_IDLE);
        case (r_state)
            acl_pkg::S_IDLE: begin
                if (start) begin
                    o_ctl.capture = 1'b1;
                    n_err         = 1'b0;
                    n_state       = acl_pkg::S_EXEC;
                end
            end
            acl_pkg::S_EXEC: begin
                n_state = acl_pkg::S_RESP;
                case (i_stat.cmd)
                    acl_pkg::CMD_ADD: begin
                        if (i_stat.ent_full) begin
                            n_err = 1'b1;
                        end else begin
                            o_ctl.wr_en        = 1'b1;
                            o_ctl.wr_addr      = acl_pkg::ENT_AW'(i_stat.ent_total);
                            o_ctl.wr_from_item = 1'b1;
                            o_ctl.ent_inc      = 1'b1;
                        end
                    end
                    acl_pkg::CMD_REMOVE: begin
                        if (i_stat.idx_bad) begin
                            n_err = 1'b1;
                        end else if (idx_p1 < total_x) begin
                            o_ctl.rd_en   = 1'b1;
                            o_ctl.rd_addr = acl_pkg::ENT_AW'(idx_p1);
                            n_ptr         = acl_pkg::ENT_AW'(i_stat.idx);
                            n_state       = acl_pkg::S_SHIFT;
                        end else begin
                            o_ctl.ent_dec = 1'b1;
                        end
                    end
                    acl_pkg::CMD_LOAD: begin
                        if (i_stat.grp_full) begin
                            n_err = 1'b1;
                        end else begin
                            o_ctl.grp_load = 1'b1;
                        end
                    end
                    default: begin
                        o_ctl.acc_clr = 1'b1;
                        if (i_stat.ent_total != '0) begin
                            o_ctl.rd_en   = 1'b1;
                            o_ctl.rd_addr = '0;
                            n_ptr         = '0;
                            n_state       = acl_pkg::S_CHECK;
                        end
                    end
                endcase
            end
            acl_pkg::S_SHIFT: begin
                // Entry at r_ptr+1 is in the read register; move it down one place.
                o_ctl.wr_en   = 1'b1;
                o_ctl.wr_addr = r_ptr;
                if (ptr_p2 < total_x) begin
                    o_ctl.rd_en   = 1'b1;
                    o_ctl.rd_addr = acl_pkg::ENT_AW'(ptr_p2);
                    n_ptr         = acl_pkg::ENT_AW'(ptr_p1);
                end else begin
                    o_ctl.ent_dec = 1'b1;
                    n_state       = acl_pkg::S_RESP;
                end
            end
            acl_pkg::S_CHECK: begin
                o_ctl.acc_en = 1'b1;
                if (ptr_p1 < total_x) begin
                    o_ctl.rd_en   = 1'b1;
                    o_ctl.rd_addr = acl_pkg::ENT_AW'(ptr_p1);
                    n_ptr         = acl_pkg::ENT_AW'(ptr_p1);
                end else begin
                    n_state = acl_pkg::S_RESP;
                end
            end
            acl_pkg::S_RESP: begin
                o_ctl.resp     = 1'b1;
                o_ctl.resp_err = r_err;
                o_ctl.resp_chk = (i_stat.cmd == acl_pkg::CMD_CHECK);
                o_ctl.grp_clr  = (i_stat.cmd == acl_pkg::CMD_CHECK);
                n_state        = acl_pkg::S_IDLE;
            end
            default: begin
                n_state = acl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/acl_dp.sv
module acl_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  acl_pkg::t_acl_in    i_item,
    input  acl_pkg::t_acl_ctl   i_ctl,
    output acl_pkg::t_acl_stat  o_stat,
    output logic                o_strobe,
    output acl_pkg::t_acl_out   o_result
);

    acl_pkg::t_acl_in             r_item;
    acl_pkg::t_acl_entry          r_mem [acl_pkg::MAX_ENTRIES];
    acl_pkg::t_acl_entry          r_rd_data;
    acl_pkg::t_acl_entry          wr_data;
    logic [31:0]                  r_grp [acl_pkg::MAX_GROUPS];
    logic [acl_pkg::ENT_CW-1:0]   r_ent_total;
    logic [acl_pkg::GRP_CW-1:0]   r_grp_total;
    logic [15:0]                  r_allow;
    logic [15:0]                  r_deny;
    logic                         grp_hit;
    logic                         hit;
    logic [15:0]                  effective;
    logic                         r_strobe;
    acl_pkg::t_acl_out            r_out;

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_item <= i_item;
        end
    end

    assign wr_data = i_ctl.wr_from_item
        ? acl_pkg::t_acl_entry'{kind:    r_item.entry_type,
                                subject: r_item.principal,
                                group:   r_item.grp_flag,
                                mask:    r_item.perms}
        : r_rd_data;

    // Entry table: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_ctl.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.grp_load) begin
            r_grp[acl_pkg::GRP_AW'(r_grp_total)] <= r_item.principal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_total <= '0;
            r_grp_total <= '0;
        end else begin
            if (i_ctl.ent_inc) begin
                r_ent_total <= r_ent_total + acl_pkg::ENT_CW'(1);
            end else if (i_ctl.ent_dec) begin
                r_ent_total <= r_ent_total - acl_pkg::ENT_CW'(1);
            end
            if (i_ctl.grp_clr) begin
                r_grp_total <= '0;
            end else if (i_ctl.grp_load) begin
                r_grp_total <= r_grp_total + acl_pkg::GRP_CW'(1);
            end
        end
    end

    // Group entries match any loaded group id; all slots compare at once.
    always_comb begin
        grp_hit = 1'b0;
        for (int j = 0; j < acl_pkg::MAX_GROUPS; j++) begin
            if ((acl_pkg::GRP_CW'(j) < r_grp_total) &&
                (r_grp[acl_pkg::GRP_AW'(j)] == r_rd_data.subject)) begin
                grp_hit = 1'b1;
            end
        end
    end

    assign hit = r_rd_data.group ? grp_hit : (r_rd_data.subject == r_item.principal);

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_clr) begin
            r_allow <= '0;
            r_deny  <= '0;
        end else if (i_ctl.acc_en && hit) begin
            if (r_rd_data.kind == acl_pkg::KIND_ALLOW) begin
                r_allow <= r_allow | r_rd_data.mask;
            end else if (r_rd_data.kind == acl_pkg::KIND_DENY) begin
                r_deny <= r_deny | r_rd_data.mask;
            end
        end
    end

    assign effective = r_allow & ~r_deny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_ctl.resp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.resp) begin
            r_out.status        <= i_ctl.resp_err;
            r_out.granted       <= i_ctl.resp_chk && ((effective & r_item.perms) == r_item.perms);
            r_out.valid_entries <= 5'(r_ent_total);
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    always_comb begin
        o_stat.cmd       = r_item.command;
        o_stat.idx       = r_item.index;
        o_stat.ent_total = r_ent_total;
        o_stat.ent_full  = (acl_pkg::CMP_W'(r_ent_total) >= acl_pkg::CMP_W'(acl_pkg::MAX_ENTRIES));
        o_stat.grp_full  = (acl_pkg::CMP_W'(r_grp_total) >= acl_pkg::CMP_W'(acl_pkg::MAX_GROUPS));
        o_stat.idx_bad   = (acl_pkg::CMP_W'(r_item.index) >= acl_pkg::CMP_W'(r_ent_total));
    end

endmodule

>>> sv/acl_permission_table.sv
// Access-control table with deny-overrides-allow checking. A command is
// transferred when start is high and busy is low; the block then stays busy
// until its single result has been produced. The result is shown on o_result
// for exactly one cycle, marked by o_strobe, and the receiver cannot stall it,
// so it must take every result in that cycle. Busy drops in the same cycle
// the strobe rises, so the next command may be transferred while a result is
// on the ports. Add and load-group commands pass through the execute and
// response states to the strobe. A check walks the valid entries one per
// cycle through the single read port of the entry table, comparing each
// against the uid and all loaded group ids at once. A remove moves each
// later entry down one place per cycle over the same port. Errors (table
// full, group buffer full, index out of range) report status 1 and leave
// the state as it was. Every check empties the group buffer.
module acl_permission_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  acl_pkg::t_acl_in   i_item,
    output logic               o_strobe,
    output acl_pkg::t_acl_out  o_result
);

    acl_pkg::t_acl_ctl   ctl;
    acl_pkg::t_acl_stat  stat;

    // The controller sequences each command; the datapath holds the table,
    // the group buffer, the counts, the accumulators and the result register.
    acl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    acl_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_ctl    (ctl),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // A result only follows a cycle in which the block was busy.
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a command in flight");

    // A transferred command always makes the block busy next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not start work");

    // The entry count never exceeds the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.ent_total <= acl_pkg::ENT_CW'(acl_pkg::MAX_ENTRIES))
        else $error("entry count beyond table size");

    // An error result never grants access.
    a_err_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status) |-> !o_result.granted)
        else $error("error result with access granted");

endmodule
